// ----- hdl/smmm_pkg.sv -----
// ============================================================================
// smmm_pkg: shared definitions for the min/median/max sorting block
// Sizes of the sample store and the state encoding of the sequencer.
// ============================================================================
package smmm_pkg;

  localparam int unsigned MAX_SAMPLES = 64;
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned COUNT_OUT_W = 7;

  typedef logic [SAMPLE_W-1:0]    sample_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [COUNT_OUT_W-1:0] count_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FETCH,
    ST_ISSUE,
    ST_SCAN,
    ST_WB,
    ST_RMIN,
    ST_RMED,
    ST_RMAX,
    ST_RDONE,
    ST_OUT
  } state_e;

endpackage

// ----- hdl/smmm_if.sv -----
// ============================================================================
// smmm_if: valid/ready channels of the min/median/max sorting block
// One interface for the sample requests and one for the result requests.
// ============================================================================
interface smmm_in_if;
  import smmm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;
  logic    no_sample;

  modport source (output valid, output sample, output last, output no_sample, input ready);
  modport sink   (input valid, input sample, input last, input no_sample, output ready);
endinterface

interface smmm_out_if;
  import smmm_pkg::*;

  logic       valid;
  logic       ready;
  sample_t    minimum;
  sample_t    median;
  sample_t    maximum;
  count_out_t sample_count;
  logic       empty_set;
  logic       overflowed;

  modport source (output valid, output minimum, output median, output maximum,
                  output sample_count, output empty_set, output overflowed, input ready);
  modport sink   (input valid, input minimum, input median, input maximum,
                  input sample_count, input empty_set, input overflowed, output ready);
endinterface

// ----- hdl/smmm_ram.sv -----
// ============================================================================
// smmm_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ============================================================================
module smmm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sorted_min_median_max.sv -----
// ============================================================================
// sorted_min_median_max: minimum, median and maximum of a set of samples
// Samples are loaded one per request, one per cycle, into a 64-entry memory;
// a request with last or no_sample set ends the set. The stored set is then
// sorted in place by one comparator that makes one pass per position but the
// last: the pass holds the current candidate in a register, reads the later
// entries one per cycle and swaps on a smaller value. No request is taken
// while the set is sorted or while the result waits. For a set of n samples,
// the median is the sorted entry at index n/2. Samples past capacity are
// dropped and reported by overflowed; an empty set gives zeros and empty_set.
// ============================================================================
module sorted_min_median_max (
  input  logic clk_i,
  input  logic rst_ni,
  smmm_in_if.sink    in_i,
  smmm_out_if.source out_o
);
  import smmm_pkg::*;

  state_e  state_q, state_d;
  cnt_t    cnt_q, cnt_d;
  logic    ovf_q, ovf_d;
  addr_t   i_q, i_d;
  cnt_t    j_q, j_d;
  addr_t   rj_q, rj_d;
  sample_t cur_q, cur_d;
  sample_t res_min_q, res_min_d;
  sample_t res_med_q, res_med_d;
  sample_t res_max_q, res_max_d;
  logic    res_empty_q, res_empty_d;

  logic    ram_we;
  addr_t   ram_waddr;
  sample_t ram_wdata;
  addr_t   ram_raddr;
  sample_t ram_rdata;

  logic    in_acc;
  cnt_t    n_new;
  cnt_t    cnt_m1;
  cnt_t    cnt_half;
  cnt_t    i_plus2;
  logic    [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  smmm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_acc   = in_i.valid && (state_q == ST_LOAD);
  assign cnt_m1   = cnt_q - cnt_t'(1);
  assign cnt_half = cnt_q >> 1;
  assign i_plus2  = cnt_t'(i_q) + cnt_t'(2);
  assign cnt_ext  = {{COUNT_OUT_W{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    rj_q        <= rj_d;
    cur_q       <= cur_d;
    res_min_q   <= res_min_d;
    res_med_q   <= res_med_d;
    res_max_q   <= res_max_d;
    res_empty_q <= res_empty_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    rj_d        = rj_q;
    cur_d       = cur_q;
    res_min_d   = res_min_q;
    res_med_d   = res_med_q;
    res_max_d   = res_max_q;
    res_empty_d = res_empty_q;
    ram_we      = 1'b0;
    ram_waddr   = rj_q;
    ram_wdata   = cur_q;
    ram_raddr   = '0;
    n_new       = cnt_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (!in_i.no_sample) begin
            if (cnt_q < cnt_t'(MAX_SAMPLES)) begin
              ram_we    = 1'b1;
              ram_waddr = cnt_q[ADDR_W-1:0];
              ram_wdata = in_i.sample;
              n_new     = cnt_q + cnt_t'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          cnt_d = n_new;
          if (in_i.last || in_i.no_sample) begin
            i_d = '0;
            if (n_new == '0) begin
              res_min_d   = '0;
              res_med_d   = '0;
              res_max_d   = '0;
              res_empty_d = 1'b1;
              state_d     = ST_OUT;
            end else if (n_new == cnt_t'(1)) begin
              state_d = ST_RMIN;
            end else begin
              state_d = ST_FETCH;
            end
          end
        end
      end
      ST_FETCH: begin
        ram_raddr = i_q;
        j_d       = cnt_t'(i_q) + cnt_t'(1);
        state_d   = ST_ISSUE;
      end
      ST_ISSUE: begin
        cur_d     = ram_rdata;
        ram_raddr = j_q[ADDR_W-1:0];
        rj_d      = j_q[ADDR_W-1:0];
        j_d       = j_q + cnt_t'(1);
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        // A smaller entry takes the candidate's place and becomes the candidate.
        if (ram_rdata < cur_q) begin
          ram_we    = 1'b1;
          ram_waddr = rj_q;
          ram_wdata = cur_q;
          cur_d     = ram_rdata;
        end
        if (j_q < cnt_q) begin
          ram_raddr = j_q[ADDR_W-1:0];
          rj_d      = j_q[ADDR_W-1:0];
          j_d       = j_q + cnt_t'(1);
        end else begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = cur_q;
        i_d       = i_q + addr_t'(1);
        if ((i_plus2 + cnt_t'(1)) < (cnt_q + cnt_t'(1)) && i_plus2 < cnt_q) begin
          state_d = ST_FETCH;
        end else begin
          state_d = ST_RMIN;
        end
      end
      ST_RMIN: begin
        ram_raddr = '0;
        state_d   = ST_RMED;
      end
      ST_RMED: begin
        res_min_d = ram_rdata;
        ram_raddr = cnt_half[ADDR_W-1:0];
        state_d   = ST_RMAX;
      end
      ST_RMAX: begin
        res_med_d = ram_rdata;
        ram_raddr = cnt_m1[ADDR_W-1:0];
        state_d   = ST_RDONE;
      end
      ST_RDONE: begin
        res_max_d   = ram_rdata;
        res_empty_d = 1'b0;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (out_o.ready) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign in_i.ready         = (state_q == ST_LOAD);
  assign out_o.valid        = (state_q == ST_OUT);
  assign out_o.minimum      = res_min_q;
  assign out_o.median       = res_med_q;
  assign out_o.maximum      = res_max_q;
  assign out_o.sample_count = cnt_ext[COUNT_OUT_W-1:0];
  assign out_o.empty_set    = res_empty_q;
  assign out_o.overflowed   = ovf_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(MAX_SAMPLES))
    else $error("stored count exceeds the store depth");

  a_pass_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> (i_plus2 <= cnt_q))
    else $error("sort pass started past the last position");

  a_scan_ports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && ram_we && j_q < cnt_q) |-> (ram_waddr != ram_raddr))
    else $error("scan writes the entry it is reading");

  a_out_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready) |=> (cnt_q == '0 && !ovf_q && state_q == ST_LOAD))
    else $error("set state not cleared after the result request");

  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.empty_set) |-> (cnt_q == '0))
    else $error("empty result with stored samples");

endmodule
